[hdl/csim_pkg.sv]
package csim_pkg;

  localparam int unsigned MaxDim = 1024;
  localparam int unsigned CntW = $clog2(MaxDim + 1);
  localparam int unsigned ElemW = 16;
  localparam int unsigned SumW = 48;
  localparam int unsigned ProdW = 2 * SumW;
  localparam int unsigned WideW = 128;
  localparam int unsigned QW = 16;
  localparam logic [QW-1:0] SatMax = 16'h7fff;

  typedef struct packed {
    logic [SumW-1:0]        sum_xx;
    logic [SumW-1:0]        sum_yy;
    logic signed [SumW-1:0] sum_xy;
  } sums_t;

endpackage

[hdl/csim_in_if.sv]
interface csim_in_if import csim_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ElemW-1:0] x_element;
  logic signed [ElemW-1:0] y_element;
  logic                    last;

  modport source (output valid, x_element, y_element, last, input ready);
  modport sink (input valid, x_element, y_element, last, output ready);
endinterface

[hdl/csim_out_if.sv]
interface csim_out_if import csim_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [QW-1:0] similarity;
  logic                 zero_norm;

  modport source (output valid, similarity, zero_norm, input ready);
  modport sink (input valid, similarity, zero_norm, output ready);
endinterface

[hdl/csim_front.sv]
module csim_front import csim_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  csim_in_if.sink     in_i,
  input  logic [1:0]  q_count_i,
  output logic        push_o,
  output sums_t       push_data_o
);

  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   v_q, last_q;
  logic [31:0]            pxx_q, pyy_q;
  logic signed [31:0]     pxy_q;
  logic [SumW-1:0]        axx_q, ayy_q;
  logic signed [SumW-1:0] axy_q;
  logic                   accept, room;
  logic [1:0]             pend;
  logic signed [31:0]     mxx, myy, mxy;
  sums_t                  nsum;

  assign pend = q_count_i + {1'b0, v_q & last_q};
  assign in_i.ready = (pend < 2'd2);
  assign accept = in_i.valid & in_i.ready;
  assign room = (cnt_q < CntW'(MaxDim));

  assign mxx = 32'(in_i.x_element) * 32'(in_i.x_element);
  assign myy = 32'(in_i.y_element) * 32'(in_i.y_element);
  assign mxy = 32'(in_i.x_element) * 32'(in_i.y_element);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (in_i.last) begin
        cnt_d = '0;
      end else if (room) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  assign nsum.sum_xx = axx_q + {16'b0, pxx_q};
  assign nsum.sum_yy = ayy_q + {16'b0, pyy_q};
  assign nsum.sum_xy = axy_q + SumW'(pxy_q);
  assign push_o = v_q & last_q;
  assign push_data_o = nsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      v_q <= 1'b0;
      last_q <= 1'b0;
      axx_q <= '0;
      ayy_q <= '0;
      axy_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      v_q <= accept;
      if (accept) begin
        last_q <= in_i.last;
      end
      if (v_q) begin
        if (last_q) begin
          axx_q <= '0;
          ayy_q <= '0;
          axy_q <= '0;
        end else begin
          axx_q <= nsum.sum_xx;
          ayy_q <= nsum.sum_yy;
          axy_q <= nsum.sum_xy;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pxx_q <= room ? mxx : '0;
      pyy_q <= room ? myy : '0;
      pxy_q <= room ? mxy : '0;
    end
  end

endmodule

[hdl/csim_fifo.sv]
module csim_fifo import csim_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sums_t      push_data_i,
  input  logic       pop_i,
  output sums_t      pop_data_o,
  output logic       not_empty_o,
  output logic [1:0] count_o
);

  sums_t      mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign pop_data_o = mem_q[rp_q];
  assign not_empty_o = (cnt_q != 2'd0);
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule

[hdl/csim_back.sv]
module csim_back import csim_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  sums_t       q_data_i,
  output logic        pop_o,
  csim_out_if.source  out_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StSrA  = 3'd2;
  localparam logic [2:0] StSrB  = 3'd3;
  localparam logic [2:0] StSrC  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]       st_q;
  logic [5:0]       step_q;
  logic [3:0]       k_q;
  logic [SumW-1:0]  amp_q, dmp_q;
  logic [ProdW-1:0] amc_q, dmc_q, p_q, d2_q;
  logic [WideW-1:0] t_q, u_q, s_q, c_q, un_q, rhs;
  logic [QW-1:0]    qv_q;
  logic             neg_q, zero_q;
  logic [SumW-1:0]  mag;
  logic [WideW-1:0] pext;

  assign pop_o = (st_q == StIdle) && q_valid_i;
  assign mag = q_data_i.sum_xy[SumW-1] ? SumW'(-q_data_i.sum_xy) : q_data_i.sum_xy;
  assign pext = {32'b0, p_q};
  assign rhs = {2'b0, d2_q, 30'b0};

  assign out_o.valid = (st_q == StDone);
  assign out_o.zero_norm = zero_q;
  always_comb begin
    if (zero_q) begin
      out_o.similarity = '0;
    end else if (neg_q) begin
      out_o.similarity = -qv_q;
    end else begin
      out_o.similarity = (qv_q > SatMax) ? SatMax : qv_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      t_q <= '0;
      d2_q <= '0;
      zero_q <= 1'b0;
    end else begin
      unique case (st_q)
        StIdle: begin
          if (q_valid_i) begin
            zero_q <= (q_data_i.sum_xx == '0) || (q_data_i.sum_yy == '0);
            neg_q <= q_data_i.sum_xy[SumW-1];
            amp_q <= q_data_i.sum_xx;
            amc_q <= {48'b0, q_data_i.sum_yy};
            dmp_q <= mag;
            dmc_q <= {48'b0, mag};
            p_q <= '0;
            d2_q <= '0;
            t_q <= '0;
            u_q <= '0;
            qv_q <= '0;
            step_q <= '0;
            k_q <= 4'd15;
            st_q <= ((q_data_i.sum_xx == '0) || (q_data_i.sum_yy == '0)) ? StDone : StMul;
          end
        end
        StMul: begin
          if (amp_q[0]) begin
            p_q <= p_q + amc_q;
          end
          if (dmp_q[0]) begin
            d2_q <= d2_q + dmc_q;
          end
          amp_q <= amp_q >> 1;
          dmp_q <= dmp_q >> 1;
          amc_q <= amc_q << 1;
          dmc_q <= dmc_q << 1;
          step_q <= step_q + 6'd1;
          if (step_q == 6'(SumW - 1)) begin
            st_q <= StSrA;
          end
        end
        StSrA: begin
          s_q <= t_q + (u_q << ({1'b0, k_q} + 5'd1));
          st_q <= StSrB;
        end
        StSrB: begin
          c_q <= s_q + (pext << {k_q, 1'b0});
          un_q <= u_q + (pext << k_q);
          st_q <= StSrC;
        end
        StSrC: begin
          if (c_q <= rhs) begin
            t_q <= c_q;
            u_q <= un_q;
            qv_q <= qv_q | (QW'(1) << k_q);
          end
          k_q <= k_q - 4'd1;
          st_q <= (k_q == 4'd0) ? StDone : StSrA;
        end
        StDone: begin
          if (out_o.ready) begin
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_norm |-> out_o.similarity == '0)
    else $error("zero norm result not zero");
  a_pop_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (st_q == StMul) || (st_q == StDone))
    else $error("pop did not start work");
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StSrA) |-> t_q <= rhs)
    else $error("search exceeded bound");

endmodule

[hdl/cosine_similarity_stream_top.sv]
// Channel  Dir  Payload
// in_i     in   x_element[15:0] signed, y_element[15:0] signed, last
// out_o    out  similarity[15:0] signed, zero_norm
//
// The front takes one element pair per cycle while in_i.ready is high and
// accumulates in two stages. The back takes one vector result at a time: the
// 48-step shift-add multiplier, the 16-bit square root search through StSrA,
// StSrB and StSrC per bit, then any wait on out_o.ready (zero norm skips both).
// A two-entry queue holds finished sums, so the front keeps taking pairs while
// the back works or waits on out_o.ready; in_i.ready drops at two queued or pending sums.
// Reset is asynchronous and active low and leaves the front's running sums at zero.
module cosine_similarity_stream_top import csim_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  csim_in_if.sink     in_i,
  csim_out_if.source  out_o
);

  logic       push, pop, nempty;
  logic [1:0] qcnt;
  sums_t      pdata, qdata;

  csim_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_i), .q_count_i(qcnt),
    .push_o(push), .push_data_o(pdata)
  );

  csim_fifo u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(push), .push_data_i(pdata),
    .pop_i(pop), .pop_data_o(qdata), .not_empty_o(nempty), .count_o(qcnt)
  );

  csim_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .q_valid_i(nempty), .q_data_i(qdata),
    .pop_o(pop), .out_o(out_o)
  );

endmodule

[test/cosine_similarity_stream_top_tb.sv]
module cosine_similarity_stream_top_tb import csim_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [QW-1:0] similarity;
    logic                 zero_norm;
  } sim_result_t;

  localparam int unsigned CycleLimit = 1000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  csim_in_if  in_ch ();
  csim_out_if out_ch ();

  cosine_similarity_stream_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #4 clk_i = ~clk_i;

  logic [SumW-1:0]        acc_xx;
  logic [SumW-1:0]        acc_yy;
  logic signed [SumW-1:0] acc_xy;
  int unsigned            pair_count;
  sim_result_t            pending_results[$];
  int unsigned            error_count;
  int unsigned            cycle_count;
  int unsigned            gap_max;
  int unsigned            stall_pct;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.x_element = '0;
    in_ch.y_element = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    acc_xx = '0;
    acc_yy = '0;
    acc_xy = '0;
    pair_count = 0;
    error_count = 0;
    cycle_count = 0;
    gap_max = 4;
    stall_pct = 30;
  end

  function automatic logic signed [QW-1:0] cosine_q15(logic [SumW-1:0] sxx,
                                                      logic [SumW-1:0] syy,
                                                      logic signed [SumW-1:0] sxy);
    logic [SumW-1:0] mag;
    logic [255:0]    norm_prod;
    logic [255:0]    rhs;
    logic [255:0]    lhs;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    mag = sxy[SumW-1] ? SumW'(-sxy) : SumW'(sxy);
    norm_prod = 256'(sxx) * 256'(syy);
    rhs = (256'(mag) * 256'(mag)) << 30;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = norm_prod * 256'(mid * mid);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (sxy[SumW-1]) return QW'(-lo);
    if (lo > 32767) lo = 32767;
    return QW'(lo);
  endfunction

  task automatic predict_pair(logic signed [ElemW-1:0] x, logic signed [ElemW-1:0] y,
                              logic last);
    sim_result_t res;
    if (pair_count < MaxDim) begin
      acc_xx += SumW'(32'(x) * 32'(x));
      acc_yy += SumW'(32'(y) * 32'(y));
      acc_xy += SumW'(signed'(32'(x) * 32'(y)));
      pair_count++;
    end
    if (last) begin
      if (acc_xx == '0 || acc_yy == '0) begin
        res.similarity = '0;
        res.zero_norm = 1'b1;
      end else begin
        res.similarity = cosine_q15(acc_xx, acc_yy, acc_xy);
        res.zero_norm = 1'b0;
      end
      pending_results = {pending_results, res};
      acc_xx = '0;
      acc_yy = '0;
      acc_xy = '0;
      pair_count = 0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic send_pair(logic signed [ElemW-1:0] x, logic signed [ElemW-1:0] y,
                           logic last);
    int unsigned gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.x_element <= x;
    in_ch.y_element <= y;
    in_ch.last <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_pair(x, y, last);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [ElemW-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return ElemW'($urandom_range(0, 15)) - 16'sd8;
      default: return ElemW'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", out_ch.similarity, 0);
      end else begin
        if (out_ch.similarity !== pending_results[0].similarity)
          report_mismatch("similarity", out_ch.similarity, pending_results[0].similarity);
        if (out_ch.zero_norm !== pending_results[0].zero_norm)
          report_mismatch("zero_norm", out_ch.zero_norm, pending_results[0].zero_norm);
        void'(pending_results.pop_front());
      end
    end
  end

  task automatic test_extremes();
    send_pair(16'sh7fff, 16'sh7fff, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7fff, 16'sh8001, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh0001, 16'sh0002, 1'b0);
    send_pair(16'sh0003, 16'sh0006, 1'b1);
    send_pair(16'sh1000, 16'sh0000, 1'b0);
    send_pair(16'sh0000, 16'sh1000, 1'b1);
    send_pair(16'sh5555, 16'shaaaa, 1'b0);
    send_pair(16'shaaaa, 16'sh5555, 1'b1);
  endtask

  task automatic test_zero_norm();
    send_pair('0, '0, 1'b1);
    send_pair('0, 16'sh1234, 1'b0);
    send_pair('0, 16'sh8000, 1'b1);
    send_pair(16'sh7fff, '0, 1'b1);
    send_pair(16'sh0001, 16'sh0001, 1'b1);
  endtask

  task automatic test_overlong_vector();
    for (int i = 0; i < MaxDim + 6; i++)
      send_pair(i < MaxDim ? 16'sh8000 : 16'sh1234, i < MaxDim ? 16'sh8000 : 16'sh8765,
                i == MaxDim + 5);
  endtask

  task automatic test_random_vectors(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        send_pair(rand_elem(), rand_elem(), i == len - 1);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        gap_max = $urandom_range(0, 20);
        stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 80);
      end
    end
  endtask

  task automatic test_pause_until_drained();
    send_pair(16'sh0100, 16'sh0200, 1'b0);
    send_pair(16'sh0300, 16'shfc00, 1'b1);
    wait_drained();
    send_pair(16'sh0400, 16'sh0400, 1'b1);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_zero_norm();
    test_pause_until_drained();
    test_random_vectors(150);
    gap_max = 0;
    stall_pct = 0;
    test_random_vectors(30);
    test_overlong_vector();
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/csim_pkg.sv
hdl/csim_in_if.sv
hdl/csim_out_if.sv
hdl/csim_front.sv
hdl/csim_fifo.sv
hdl/csim_back.sv
hdl/cosine_similarity_stream_top.sv
test/cosine_similarity_stream_top_tb.sv
